@@ sv/mcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// mcbp_pkg
// Shared types and codes for the multi-channel byte pipe.
// ----------------------------------------------------------------------------
package mcbp_pkg;

  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLOSE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_NO_PIPE = 2'd2;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  op;
    logic        bad;
    logic [5:0]  pipe;
    logic        is_rd;
    logic [63:0] wdata;
    logic [3:0]  count;
  } cmd_t;

  // Result item from the back part.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  moved;
    logic [63:0] rdata;
    logic [4:0]  new_rd;
    logic [4:0]  new_wr;
  } res_t;

endpackage

@@ sv/mcbp_ram.sv @@
// ----------------------------------------------------------------------------
// mcbp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/mcbp_front.sv @@
// ----------------------------------------------------------------------------
// mcbp_front
// Accepts items, decodes the handle and saturates the count.
// ----------------------------------------------------------------------------
module mcbp_front #(
  parameter int unsigned NUM_PIPES    = 8,
  parameter int unsigned FIRST_HANDLE = 3,
  parameter int unsigned MAX_BURST    = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic [1:0]         opcode,
  input  logic [4:0]         handle,
  input  logic [63:0]        write_bytes,
  input  logic [3:0]         byte_count,
  output logic               q_valid,
  input  logic               q_ready,
  output mcbp_pkg::cmd_t     q_cmd
);
  import mcbp_pkg::*;

  localparam int unsigned DEPTH = 2;

  cmd_t       fifo [DEPTH];
  logic       wp, rp;
  logic [1:0] fill;
  cmd_t       cmd;
  logic [7:0] off;
  logic       push, pop;

  // Decode one item.
  always_comb begin
    off = 8'(handle) - 8'(FIRST_HANDLE);
    cmd.op    = opcode;
    cmd.wdata = write_bytes;
    cmd.count = (byte_count > 4'(MAX_BURST)) ? 4'(MAX_BURST) : byte_count;
    cmd.bad   = (8'(handle) < 8'(FIRST_HANDLE)) ||
                (off >= 8'(2 * NUM_PIPES));
    cmd.pipe  = off[6:1];
    // An even offset names a read end.
    cmd.is_rd = !off[0];
    if (opcode != OP_CLOSE) begin
      // Wrong-end check: even offset is a read end.
      if (opcode == OP_WRITE && !off[0]) cmd.bad = 1'b1;
      if (opcode == OP_READ && off[0])   cmd.bad = 1'b1;
    end
  end

  assign ready   = fill != 2'd2;
  assign q_valid = fill != 2'd0;
  assign q_cmd   = fifo[rp];
  assign push    = valid && ready;
  assign pop     = q_valid && q_ready;

  // Short queue toward the back part.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= cmd;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ sv/mcbp_back.sv @@
// ----------------------------------------------------------------------------
// mcbp_back
// Executes queued items against pipe state and the banked byte store.
// ----------------------------------------------------------------------------
module mcbp_back #(
  parameter int unsigned NUM_PIPES    = 8,
  parameter int unsigned PIPE_DEPTH   = 4096,
  parameter int unsigned FIRST_HANDLE = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  mcbp_pkg::cmd_t q_cmd,
  output logic           valid,
  input  logic           ready,
  output mcbp_pkg::res_t res
);
  import mcbp_pkg::*;

  localparam int unsigned PW = $clog2(NUM_PIPES) > 0 ? $clog2(NUM_PIPES) : 1;
  localparam int unsigned AW = $clog2(PIPE_DEPTH);
  localparam int unsigned BAW = $clog2(NUM_PIPES * PIPE_DEPTH);
  localparam int unsigned RW = BAW - 3;

  typedef enum logic [1:0] {S_EXEC, S_READ, S_OUT} state_t;
  state_t state;

  logic [NUM_PIPES-1:0] rd_open, wr_open;
  logic [AW:0] rptr [NUM_PIPES];
  logic [AW:0] wptr [NUM_PIPES];

  logic [PW-1:0] p;
  logic [AW:0]   held, avail, base, ptr;
  logic [3:0]    n;
  logic [PW-1:0] free_p;
  logic          free_ok;
  logic [7:0]    bwe;
  logic [RW-1:0] baddr [8];
  logic [7:0]    bw [8];
  logic [7:0]    br [8];
  logic [2:0]    rot;
  logic [3:0]    rn;
  res_t          exec_res;
  logic          exec_rd;
  logic          end_open;

  assign p = q_cmd.pipe[PW-1:0];
  assign held = wptr[p] - rptr[p];
  assign avail = (AW+1)'(PIPE_DEPTH) - held;
  assign ptr = (q_cmd.op == OP_READ) ? rptr[p] : wptr[p];
  assign base = '0;

  // Byte count this item moves.
  always_comb begin
    if (q_cmd.op == OP_WRITE)
      n = ((AW+1)'(q_cmd.count) < avail) ? q_cmd.count : 4'(avail);
    else
      n = ((AW+1)'(q_cmd.count) < held) ? q_cmd.count : 4'(held);
  end

  // First pipe with both ends closed.
  always_comb begin
    free_ok = 1'b0;
    free_p = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!rd_open[i] && !wr_open[i]) begin
        free_ok = 1'b1;
        free_p = PW'(i);
      end
    end
  end

  // Result of the item at the head of the queue.
  always_comb begin
    exec_res = '0;
    exec_rd = 1'b0;
    end_open = q_cmd.is_rd ? rd_open[p] : wr_open[p];
    if (q_cmd.op == OP_CREATE) begin
      if (!free_ok) begin
        exec_res.status = ST_NO_PIPE;
      end else begin
        exec_res.new_rd = 5'(FIRST_HANDLE + 2 * 32'(free_p));
        exec_res.new_wr = 5'(FIRST_HANDLE + 2 * 32'(free_p) + 1);
      end
    end else if (q_cmd.bad) begin
      exec_res.status = ST_BAD;
    end else if (q_cmd.op == OP_WRITE) begin
      if (!wr_open[p]) exec_res.status = ST_BAD;
      else exec_res.moved = n;
    end else if (q_cmd.op == OP_READ) begin
      if (!rd_open[p]) begin
        exec_res.status = ST_BAD;
      end else begin
        exec_res.moved = n;
        exec_rd = 1'b1;
      end
    end else if (!end_open) begin
      exec_res.status = ST_BAD;
    end
  end

  // Eight banks; byte j of a burst lands in bank (ptr+j) mod 8, and the
  // address wraps inside the pipe's own region.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      logic [2:0] j;
      logic [AW-1:0] aoff;
      logic [BAW-1:0] a;
      j = 3'(b) - ptr[2:0];
      aoff = ptr[AW-1:0] + AW'(j);
      a = BAW'(p) * BAW'(PIPE_DEPTH) + BAW'(aoff);
      baddr[b] = a[BAW-1:3];
      bw[b] = q_cmd.wdata[8*j +: 8];
      bwe[b] = state == S_EXEC && q_valid && q_cmd.op == OP_WRITE &&
               !q_cmd.bad && wr_open[p] && (4'(j) < n);
    end
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    mcbp_ram #(.WIDTH(8), .DEPTH(1 << RW)) u_bank (
      .clk(clk), .we(bwe[b]), .addr(baddr[b]), .wdata(bw[b]), .rdata(br[b])
    );
  end

  assign q_ready = state == S_EXEC;

  // Sequencer: execute, optional bank read, present result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EXEC;
      valid <= 1'b0;
      rd_open <= '0;
      wr_open <= '0;
      for (int i = 0; i < NUM_PIPES; i++) begin
        rptr[i] <= '0;
        wptr[i] <= '0;
      end
    end else begin
      unique case (state)
        S_EXEC: if (q_valid) begin
          res <= exec_res;
          rot <= ptr[2:0];
          rn <= n;
          valid <= !exec_rd;
          state <= exec_rd ? S_READ : S_OUT;
          if (q_cmd.op == OP_CREATE) begin
            if (free_ok) begin
              rptr[free_p] <= base;
              wptr[free_p] <= base;
              rd_open[free_p] <= 1'b1;
              wr_open[free_p] <= 1'b1;
            end
          end else if (!q_cmd.bad) begin
            if (q_cmd.op == OP_WRITE) begin
              if (wr_open[p]) wptr[p] <= wptr[p] + (AW+1)'(n);
            end else if (q_cmd.op == OP_READ) begin
              if (rd_open[p]) rptr[p] <= rptr[p] + (AW+1)'(n);
            end else if (end_open) begin
              // Close one end; the pipe is freed once both are closed.
              if (q_cmd.is_rd) rd_open[p] <= 1'b0;
              else wr_open[p] <= 1'b0;
              if (q_cmd.is_rd ? !wr_open[p] : !rd_open[p]) begin
                rptr[p] <= base;
                wptr[p] <= base;
              end
            end
          end
        end
        S_READ: begin
          for (int j = 0; j < 8; j++) begin
            res.rdata[8*j +: 8] <= (4'(j) < rn) ? br[3'(j) + rot] : 8'd0;
          end
          valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (ready) begin
          valid <= 1'b0;
          state <= S_EXEC;
        end
        default: state <= S_EXEC;
      endcase
    end
  end

endmodule

@@ sv/multi_channel_byte_pipe.sv @@
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe
// Bank of byte ring-buffer pipes driven by create, write, read and close items.
// ----------------------------------------------------------------------------
// One result per item. A front stage decodes the handle into a two-entry
// queue; the back stage executes one item at a time and takes no new item
// until its result is taken. Create, write and close go from execute to
// present; read passes through an extra state for the registered read of the
// eight-way banked byte store. No clearing pass is needed.
module multi_channel_byte_pipe #(
  parameter int unsigned NUM_PIPES    = 8,
  parameter int unsigned PIPE_DEPTH   = 4096,
  parameter int unsigned FIRST_HANDLE = 3,
  parameter int unsigned MAX_BURST    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [4:0]  handle,
  input  logic [63:0] write_bytes,
  input  logic [3:0]  byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  moved_count,
  output logic [63:0] read_bytes,
  output logic [4:0]  new_read_handle,
  output logic [4:0]  new_write_handle
);
  import mcbp_pkg::*;

  logic  q_valid, q_ready;
  cmd_t  q_cmd;
  res_t  res;

  mcbp_front #(.NUM_PIPES(NUM_PIPES), .FIRST_HANDLE(FIRST_HANDLE),
               .MAX_BURST(MAX_BURST)) u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready), .opcode, .handle,
    .write_bytes, .byte_count, .q_valid, .q_ready, .q_cmd
  );

  mcbp_back #(.NUM_PIPES(NUM_PIPES), .PIPE_DEPTH(PIPE_DEPTH),
              .FIRST_HANDLE(FIRST_HANDLE)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .valid(out_valid), .ready(out_ready), .res
  );

  assign status           = res.status;
  assign moved_count      = res.moved;
  assign read_bytes       = res.rdata;
  assign new_read_handle  = res.new_rd;
  assign new_write_handle = res.new_wr;

endmodule
